// ----- hw/rtl/cgs_pkg.sv -----
// Shared types, codes and helpers for the conjugate gradient solver.
// No dependencies; every module of the block but cgs_ram imports it.
package cgs_pkg;

  localparam int MaxUnknownsDef = 16;

  // Configuration register indexes (byte address = 4 * index).
  localparam logic [1:0] RegSize  = 2'd0;
  localparam logic [1:0] RegFloor = 2'd1;
  localparam logic [1:0] RegTol   = 2'd2;

  typedef enum logic [1:0] {
    MODE_LOAD_A = 2'd0,
    MODE_LOAD_B = 2'd1,
    MODE_SOLVE  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  // Element operations run through the datapath pipeline.
  typedef enum logic [2:0] {
    OP_INIT   = 3'd0,
    OP_MATVEC = 3'd1,
    OP_DOT_PA = 3'd2,
    OP_UPD_X  = 3'd3,
    OP_UPD_R  = 3'd4,
    OP_DOT_RR = 3'd5,
    OP_UPD_P  = 3'd6,
    OP_OUT    = 3'd7
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_MV, ST_PA, ST_DIVA, ST_UX, ST_UR, ST_RR,
    ST_CHECK, ST_DIVB, ST_UP, ST_LOOP, ST_DRAIN, ST_DIVW, ST_OUTRD, ST_OUTW
  } state_e;

  typedef struct packed {
    op_e        op;
    logic       vld;
    logic       first;
    logic       last;
    logic       div_start;
    logic       div_beta;
    logic       conv;
    logic [4:0] iters;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic div_busy;
    logic conv_hit;
    logic out_taken;
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

endpackage

// ----- hw/rtl/conjugate_gradient_solver.sv -----
// Top level of the conjugate gradient solver: ports, configuration registers
// and load decode. Uses cgs_pkg, cgs_ctrl and cgs_datapath.
//
//   channel    | direction | beat contents
//   s_axis     | in        | tuser: mode; tdata: row, col, value
//   m_axis     | out       | tdata: index, solution, iterations; tuser: converged; tlast
//   apb        | in/out    | size_in_use @0x0, denom_floor @0x4, residual_tol_sq @0x8
//
// A solve for n unknowns and k iterations is dominated by the n*n
// multiply-accumulates of A*p through the single multiplier and by two
// divisions per iteration.
// Each solution beat is read from x and held until m_axis_tready takes it.
// Input is held off from a solve beat until its last result beat is taken.
// Reset clears control state only; matrix and rhs contents are undefined.
module conjugate_gradient_solver import cgs_pkg::*; #(
  parameter int MAX_UNKNOWNS = MaxUnknownsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // row[3:0], col[7:4], value[39:8]
  input  logic [1:0]  s_axis_tuser,   // mode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // index[3:0], solution[35:4], iterations[40:36]
  output logic        m_axis_tuser,   // converged[0]
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = $clog2(MAX_UNKNOWNS);

  logic [4:0]  size_q;
  logic [15:0] floor_q;
  logic [31:0] tol_q;
  logic        cfg_we;
  logic [IW-1:0] nm1, idx_i, idx_j;
  logic        in_acc, ld_a, ld_b, start;
  logic [3:0]  row, col;
  mode_e       mode;
  cmd_t        cmd;
  sts_t        sts;
  logic [3:0]  o_idx;
  logic [31:0] o_sol;
  logic [4:0]  o_it;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= 5'd16;
      floor_q <= 16'd1;
      tol_q   <= 32'd1;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        RegSize:  size_q  <= pwdata[4:0];
        RegFloor: floor_q <= pwdata[15:0];
        RegTol:   tol_q   <= pwdata;
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegSize:  prdata = {27'h0, size_q};
      RegFloor: prdata = {16'h0, floor_q};
      RegTol:   prdata = tol_q;
      default:  prdata = 32'h0;
    endcase
  end

  // clamp the unknown count to 1..MAX_UNKNOWNS
  always_comb begin
    if (size_q == '0) nm1 = '0;
    else if (32'(size_q) > MAX_UNKNOWNS) nm1 = IW'(MAX_UNKNOWNS - 1);
    else nm1 = IW'(size_q - 5'd1);
  end

  assign mode   = mode_e'(s_axis_tuser);
  assign row    = s_axis_tdata[3:0];
  assign col    = s_axis_tdata[7:4];
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign ld_a   = in_acc && mode == MODE_LOAD_A &&
                  32'(row) < MAX_UNKNOWNS && 32'(col) < MAX_UNKNOWNS;
  assign ld_b   = in_acc && mode == MODE_LOAD_B && 32'(row) < MAX_UNKNOWNS;
  assign start  = in_acc && mode == MODE_SOLVE;

  cgs_ctrl #(.MAX_UNKNOWNS(MAX_UNKNOWNS)) u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .nm1_i(nm1), .sts_i(sts),
    .in_ready_o(s_axis_tready), .cmd_o(cmd), .idx_i_o(idx_i), .idx_j_o(idx_j)
  );

  cgs_datapath #(.MAX_UNKNOWNS(MAX_UNKNOWNS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .idx_i_i(idx_i), .idx_j_i(idx_j),
    .floor_i(floor_q), .tol_i(tol_q),
    .ld_a_i(ld_a), .ld_b_i(ld_b), .ld_row_i(IW'(row)), .ld_col_i(IW'(col)),
    .ld_val_i(s_axis_tdata[39:8]),
    .out_ready_i(m_axis_tready), .out_valid_o(m_axis_tvalid),
    .out_index_o(o_idx), .out_solution_o(o_sol), .out_last_o(m_axis_tlast),
    .out_conv_o(m_axis_tuser), .out_iters_o(o_it), .sts_o(sts)
  );

  assign m_axis_tdata = {7'h0, o_it, o_sol, o_idx};

endmodule

// ----- hw/rtl/cgs_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module cgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hw/rtl/cgs_div.sv -----
// Restoring divider, one quotient bit a cycle: floor(num * 2^16 / den),
// saturated to the largest positive 32-bit value. Uses cgs_pkg.
module cgs_div import cgs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        busy_o,
  output logic [31:0] quot_o
);

  localparam int DivSteps = 80;

  logic        busy_q;
  logic [6:0]  cnt_q;
  logic [79:0] dvd_q;
  logic [63:0] rem_q, den_q;
  logic [31:0] q_q;
  logic        ovf_q;
  logic [64:0] rem_sh, rem_sub;
  logic        ge;

  assign rem_sh  = {rem_q, dvd_q[79]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign ge      = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 7'(DivSteps - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 7'd1;
      if (cnt_q == '0) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {num_i, 16'h0};
      rem_q <= '0;
      den_q <= den_i;
      q_q   <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[78:0], 1'b0};
      rem_q <= ge ? rem_sub[63:0] : rem_sh[63:0];
      q_q   <= {q_q[30:0], ge};
      ovf_q <= ovf_q | q_q[31];
    end
  end

  assign busy_o = busy_q;
  assign quot_o = (ovf_q || q_q[31]) ? 32'h7FFF_FFFF : q_q;

endmodule

// ----- hw/rtl/cgs_datapath.sv -----
// Datapath: matrix and vector RAMs, a two-stage multiply/accumulate pipeline,
// the step divider and the result register. Uses cgs_pkg, cgs_ram, cgs_div.
module cgs_datapath import cgs_pkg::*; #(
  parameter int MAX_UNKNOWNS = MaxUnknownsDef,
  localparam int IW = $clog2(MAX_UNKNOWNS),
  localparam int AW = $clog2(MAX_UNKNOWNS * MAX_UNKNOWNS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cmd_t          cmd_i,
  input  logic [IW-1:0] idx_i_i,
  input  logic [IW-1:0] idx_j_i,
  input  logic [15:0]   floor_i,
  input  logic [31:0]   tol_i,
  input  logic          ld_a_i,
  input  logic          ld_b_i,
  input  logic [IW-1:0] ld_row_i,
  input  logic [IW-1:0] ld_col_i,
  input  logic [31:0]   ld_val_i,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output logic [3:0]    out_index_o,
  output logic [31:0]   out_solution_o,
  output logic          out_last_o,
  output logic          out_conv_o,
  output logic [4:0]    out_iters_o,
  output sts_t          sts_o
);

  logic [31:0] a_rd, b_rd, x_rd, r_rd, p_rd, ap_rd;
  logic [AW-1:0] a_waddr, a_raddr;
  logic [IW-1:0] p_raddr;

  // pipeline stage registers
  logic          s1_v_q, s2_v_q;
  op_e           s1_op_q, s2_op_q;
  logic [IW-1:0] s1_i_q, s2_i_q;
  logic          s1_first_q, s1_last_q, s2_first_q, s2_last_q;
  logic [4:0]    s1_it_q;
  logic          s1_conv_q;

  logic signed [31:0] ma, mb, addend_d, addend_q, scale;
  logic signed [63:0] prod_d, prod_q, acc_q, rr_q, acc_base, acc_new, upd64;
  logic        [64:0] sum65;
  logic signed [31:0] upd, apw;
  logic        [63:0] fl, div_num, div_den;
  logic        [31:0] quot;
  logic               div_busy;

  logic x_we, r_we, p_we, ap_we;
  logic [31:0] x_wd, r_wd, p_wd;

  logic          out_v_q;
  logic [3:0]    out_idx_q;
  logic [31:0]   out_sol_q;
  logic          out_last_q, out_conv_q;
  logic [4:0]    out_it_q;

  assign a_waddr = AW'(AW'(ld_row_i) * AW'(MAX_UNKNOWNS) + AW'(ld_col_i));
  assign a_raddr = AW'(AW'(idx_i_i) * AW'(MAX_UNKNOWNS) + AW'(idx_j_i));
  assign p_raddr = (cmd_i.op == OP_MATVEC) ? idx_j_i : idx_i_i;

  cgs_ram #(.WIDTH(32), .DEPTH(MAX_UNKNOWNS * MAX_UNKNOWNS)) u_a_ram (
    .clk_i, .we_i(ld_a_i), .waddr_i(a_waddr), .wdata_i(ld_val_i),
    .raddr_i(a_raddr), .rdata_o(a_rd)
  );
  cgs_ram #(.WIDTH(32), .DEPTH(MAX_UNKNOWNS)) u_b_ram (
    .clk_i, .we_i(ld_b_i), .waddr_i(ld_row_i), .wdata_i(ld_val_i),
    .raddr_i(idx_i_i), .rdata_o(b_rd)
  );
  cgs_ram #(.WIDTH(32), .DEPTH(MAX_UNKNOWNS)) u_x_ram (
    .clk_i, .we_i(x_we), .waddr_i(s2_i_q), .wdata_i(x_wd),
    .raddr_i(idx_i_i), .rdata_o(x_rd)
  );
  cgs_ram #(.WIDTH(32), .DEPTH(MAX_UNKNOWNS)) u_r_ram (
    .clk_i, .we_i(r_we), .waddr_i(s2_i_q), .wdata_i(r_wd),
    .raddr_i(idx_i_i), .rdata_o(r_rd)
  );
  cgs_ram #(.WIDTH(32), .DEPTH(MAX_UNKNOWNS)) u_p_ram (
    .clk_i, .we_i(p_we), .waddr_i(s2_i_q), .wdata_i(p_wd),
    .raddr_i(p_raddr), .rdata_o(p_rd)
  );
  cgs_ram #(.WIDTH(32), .DEPTH(MAX_UNKNOWNS)) u_ap_ram (
    .clk_i, .we_i(ap_we), .waddr_i(s2_i_q), .wdata_i(apw),
    .raddr_i(idx_i_i), .rdata_o(ap_rd)
  );

  // stage 1: pick multiplier operands from the read data
  assign scale = $signed(quot);
  always_comb begin
    ma       = '0;
    mb       = '0;
    addend_d = '0;
    case (s1_op_q)
      OP_INIT:   begin ma = b_rd;   mb = b_rd;  addend_d = b_rd; end
      OP_MATVEC: begin ma = a_rd;   mb = p_rd;  end
      OP_DOT_PA: begin ma = p_rd;   mb = ap_rd; end
      OP_UPD_X:  begin ma = scale;  mb = p_rd;  addend_d = x_rd; end
      OP_UPD_R:  begin ma = -scale; mb = ap_rd; addend_d = r_rd; end
      OP_DOT_RR: begin ma = r_rd;   mb = r_rd;  end
      OP_UPD_P:  begin ma = scale;  mb = p_rd;  addend_d = r_rd; end
      default:   begin ma = '0;     mb = '0;    end
    endcase
  end
  assign prod_d = ma * mb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.vld;
      s2_v_q <= s1_v_q && (s1_op_q != OP_OUT);
    end
  end

  always_ff @(posedge clk_i) begin
    s1_op_q    <= cmd_i.op;
    s1_i_q     <= idx_i_i;
    s1_first_q <= cmd_i.first;
    s1_last_q  <= cmd_i.last;
    s1_it_q    <= cmd_i.iters;
    s1_conv_q  <= cmd_i.conv;
    s2_op_q    <= s1_op_q;
    s2_i_q     <= s1_i_q;
    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    prod_q     <= prod_d;
    addend_q   <= addend_d;
  end

  // stage 2: saturating accumulate and vector updates
  assign acc_base = s2_first_q ? 64'sd0 : acc_q;
  assign sum65    = {acc_base[63], acc_base} + {prod_q[63], prod_q};
  always_comb begin
    if (sum65[64] != sum65[63])
      acc_new = sum65[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    else
      acc_new = sum65[63:0];
  end
  // keep the sum signed so the product shift rounds toward minus infinity
  assign upd64 = $signed({{32{addend_q[31]}}, addend_q}) + (prod_q >>> 16);
  assign upd   = sat32(upd64);
  assign apw   = sat32(acc_new >>> 16);

  assign x_we  = s2_v_q && (s2_op_q == OP_INIT || s2_op_q == OP_UPD_X);
  assign r_we  = s2_v_q && (s2_op_q == OP_INIT || s2_op_q == OP_UPD_R);
  assign p_we  = s2_v_q && (s2_op_q == OP_INIT || s2_op_q == OP_UPD_P);
  assign ap_we = s2_v_q && (s2_op_q == OP_MATVEC) && s2_last_q;
  assign x_wd  = (s2_op_q == OP_INIT) ? 32'h0 : upd;
  assign r_wd  = (s2_op_q == OP_INIT) ? addend_q : upd;
  assign p_wd  = (s2_op_q == OP_INIT) ? addend_q : upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      rr_q  <= '0;
    end else begin
      if (s2_v_q && (s2_op_q == OP_INIT || s2_op_q == OP_MATVEC ||
                     s2_op_q == OP_DOT_PA || s2_op_q == OP_DOT_RR))
        acc_q <= acc_new;
      if (s2_v_q && s2_op_q == OP_INIT && s2_last_q) rr_q <= acc_new;
      else if (cmd_i.div_start && cmd_i.div_beta) rr_q <= acc_q;
    end
  end

  // alpha = rr / max(p.Ap, floor); beta = rr_new / max(rr_old, floor)
  assign fl = {32'h0, (floor_i == '0) ? 16'd1 : floor_i, 16'h0};
  always_comb begin
    if (cmd_i.div_beta) begin
      div_num = acc_q;
      div_den = (rr_q < $signed(fl)) ? fl : rr_q;
    end else begin
      div_num = rr_q;
      div_den = (acc_q < $signed(fl)) ? fl : acc_q;
    end
  end

  cgs_div u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i(div_num), .den_i(div_den),
    .busy_o(div_busy), .quot_o(quot)
  );

  // result register: load from the x read, hold until the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s1_v_q && s1_op_q == OP_OUT) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q && s1_op_q == OP_OUT) begin
      out_idx_q  <= 4'(s1_i_q);
      out_sol_q  <= x_rd;
      out_last_q <= s1_last_q;
      out_conv_q <= s1_conv_q;
      out_it_q   <= s1_it_q;
    end
  end

  assign out_valid_o    = out_v_q;
  assign out_index_o    = out_idx_q;
  assign out_solution_o = out_sol_q;
  assign out_last_o     = out_last_q;
  assign out_conv_o     = out_conv_q;
  assign out_iters_o    = out_it_q;

  assign sts_o.busy      = s1_v_q || s2_v_q;
  assign sts_o.div_busy  = div_busy;
  assign sts_o.conv_hit  = acc_q < $signed({32'h0, tol_i});
  assign sts_o.out_taken = out_v_q && out_ready_i;

endmodule

// ----- hw/rtl/cgs_ctrl.sv -----
// Solve sequencer: walks the element operations of each iteration, starts
// the divider and emits the results. Uses cgs_pkg.
module cgs_ctrl import cgs_pkg::*; #(
  parameter int MAX_UNKNOWNS = MaxUnknownsDef,
  localparam int IW = $clog2(MAX_UNKNOWNS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [IW-1:0] nm1_i,
  input  sts_t          sts_i,
  output logic          in_ready_o,
  output cmd_t          cmd_o,
  output logic [IW-1:0] idx_i_o,
  output logic [IW-1:0] idx_j_o
);

  state_e state_q, state_d, nxt_q, nxt_d;
  logic [IW-1:0] i_q, i_d, j_q, j_d;
  logic [4:0] it_q, it_d;
  logic conv_q, conv_d;
  logic last_i, last_j;

  assign last_i = (i_q == nm1_i);
  assign last_j = (j_q == nm1_i);

  always_comb begin
    state_d = state_q;
    nxt_d   = nxt_q;
    i_d     = i_q;
    j_d     = j_q;
    it_d    = it_q;
    conv_d  = conv_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          i_d = '0; j_d = '0; it_d = '0; conv_d = 1'b0;
          state_d = ST_INIT;
        end
      end
      ST_INIT, ST_PA, ST_UX, ST_UR, ST_RR, ST_UP: begin
        i_d = last_i ? '0 : i_q + 1'b1;
        if (last_i) begin
          state_d = ST_DRAIN;
          case (state_q)
            ST_INIT: nxt_d = ST_MV;
            ST_PA:   nxt_d = ST_DIVA;
            ST_UX:   state_d = ST_UR;
            ST_UR:   nxt_d = ST_RR;
            ST_RR:   nxt_d = ST_CHECK;
            default: nxt_d = ST_LOOP;
          endcase
        end
      end
      ST_MV: begin
        if (i_q == '0 && j_q == '0) it_d = it_q + 5'd1;
        j_d = last_j ? '0 : j_q + 1'b1;
        if (last_j) begin
          i_d = last_i ? '0 : i_q + 1'b1;
          if (last_i) begin
            state_d = ST_DRAIN;
            nxt_d   = ST_PA;
          end
        end
      end
      ST_DRAIN: if (!sts_i.busy) state_d = nxt_q;
      ST_DIVA: begin
        state_d = ST_DIVW;
        nxt_d   = ST_UX;
      end
      ST_DIVB: begin
        state_d = ST_DIVW;
        nxt_d   = ST_UP;
      end
      ST_DIVW: if (!sts_i.div_busy) state_d = nxt_q;
      ST_CHECK: begin
        if (sts_i.conv_hit) begin
          conv_d  = 1'b1;
          state_d = ST_OUTRD;
        end else begin
          state_d = ST_DIVB;
        end
      end
      ST_LOOP: begin
        if (32'(it_q) == 32'(nm1_i) + 1) state_d = ST_OUTRD;
        else state_d = ST_MV;
      end
      ST_OUTRD: state_d = ST_OUTW;
      ST_OUTW: begin
        if (sts_i.out_taken) begin
          i_d = last_i ? '0 : i_q + 1'b1;
          state_d = last_i ? ST_IDLE : ST_OUTRD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.op        = OP_INIT;
    cmd_o.first     = (i_q == '0);
    cmd_o.last      = last_i;
    cmd_o.conv      = conv_q;
    cmd_o.iters     = it_q;
    unique case (state_q)
      ST_INIT:  begin cmd_o.vld = 1'b1; cmd_o.op = OP_INIT;   end
      ST_PA:    begin cmd_o.vld = 1'b1; cmd_o.op = OP_DOT_PA; end
      ST_UX:    begin cmd_o.vld = 1'b1; cmd_o.op = OP_UPD_X;  end
      ST_UR:    begin cmd_o.vld = 1'b1; cmd_o.op = OP_UPD_R;  end
      ST_RR:    begin cmd_o.vld = 1'b1; cmd_o.op = OP_DOT_RR; end
      ST_UP:    begin cmd_o.vld = 1'b1; cmd_o.op = OP_UPD_P;  end
      ST_OUTRD: begin cmd_o.vld = 1'b1; cmd_o.op = OP_OUT;    end
      ST_MV: begin
        cmd_o.vld   = 1'b1;
        cmd_o.op    = OP_MATVEC;
        cmd_o.first = (j_q == '0);
        cmd_o.last  = last_j;
      end
      ST_DIVA: cmd_o.div_start = 1'b1;
      ST_DIVB: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_beta  = 1'b1;
      end
      default: cmd_o.vld = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      nxt_q   <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      it_q    <= '0;
      conv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      nxt_q   <= nxt_d;
      i_q     <= i_d;
      j_q     <= j_d;
      it_q    <= it_d;
      conv_q  <= conv_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign idx_i_o    = i_q;
  assign idx_j_o    = j_q;

endmodule

// ----- test/tb_conjugate_gradient_solver.sv -----
// Testbench for conjugate_gradient_solver: drives load and solve beats on s_axis,
// writes the APB registers and checks each m_axis beat against a built-in predictor.
// Depends on cgs_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_conjugate_gradient_solver;
  import cgs_pkg::*;

  localparam int Dim = 16;
  localparam int WatchLimit = 200000;

  typedef logic signed [31:0] vec_t [Dim];

  typedef struct {
    logic [3:0]  index;
    logic [31:0] solution;
    logic        last;
    logic        converged;
    logic [4:0]  iterations;
  } sol_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // row[3:0], col[7:4], value[39:8]
  logic [1:0]  s_axis_tuser = '0;   // mode[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // index[3:0], solution[35:4], iterations[40:36]
  logic        m_axis_tuser;        // converged[0]
  logic        m_axis_tlast;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  conjugate_gradient_solver dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic signed [31:0] mat_q [Dim*Dim];
  vec_t rhs_q, x_q, r_q, p_q, ap_q;
  logic signed [63:0] rr_q;
  bit   mat_set [Dim*Dim];
  bit   rhs_set [Dim];
  logic [4:0]  cfg_size = 5'd16;
  logic [15:0] cfg_floor = 16'd1;
  logic [31:0] cfg_tol = 32'd1;

  sol_beat_t solution_fifo [$];
  int  err_cnt = 0;
  int  quiet_cycles = 0;
  bit  calm = 1'b0;

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    err_cnt++;
  endtask

  function automatic logic signed [63:0] add_sat64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] inner(input vec_t a, input vec_t b, input int n);
    logic signed [63:0] acc, ea, eb;
    acc = 0;
    for (int i = 0; i < n; i++) begin
      ea = a[i];
      eb = b[i];
      acc = add_sat64(acc, ea * eb);
    end
    return acc;
  endfunction

  function automatic logic signed [31:0] q16_ratio(input logic signed [63:0] num,
                                                   input logic signed [63:0] den);
    logic [95:0] nn, dd, qq;
    nn = {32'd0, num};
    dd = {32'd0, den};
    if (nn / dd >= 96'd32768) return 32'sh7FFFFFFF;
    qq = (nn << 16) / dd;
    return qq[31:0];
  endfunction

  function automatic vec_t scaled_add(input vec_t a, input logic signed [31:0] s,
                                      input vec_t v, input int n);
    vec_t d;
    logic signed [63:0] s64, v64, a64, t;
    d = a;
    s64 = s;
    for (int i = 0; i < n; i++) begin
      v64 = v[i];
      a64 = a[i];
      t = s64 * v64;
      d[i] = clamp32(a64 + (t >>> 16));
    end
    return d;
  endfunction

  // run one solve on the predictor and queue its solution beats
  task automatic predict_solve();
    int n, it;
    bit conv;
    logic signed [63:0] fl, den, rr_new;
    logic signed [31:0] alpha, beta;
    vec_t row_v;
    sol_beat_t b;
    n = cfg_size;
    if (n < 1) n = 1;
    if (n > Dim) n = Dim;
    fl = 64'(cfg_floor == 0 ? 16'd1 : cfg_floor) << 16;
    for (int i = 0; i < n; i++) begin
      x_q[i] = 0;
      r_q[i] = rhs_q[i];
      p_q[i] = rhs_q[i];
    end
    rr_q = inner(r_q, r_q, n);
    it = 0;
    conv = 0;
    while (it < n) begin
      it++;
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < Dim; j++) row_v[j] = mat_q[i*Dim + j];
        ap_q[i] = clamp32(inner(row_v, p_q, n) >>> 16);
      end
      den = inner(p_q, ap_q, n);
      if (den < fl) den = fl;
      alpha = q16_ratio(rr_q, den);
      x_q = scaled_add(x_q, alpha, p_q, n);
      r_q = scaled_add(r_q, -alpha, ap_q, n);
      rr_new = inner(r_q, r_q, n);
      if (rr_new < $signed({32'd0, cfg_tol})) begin
        rr_q = rr_new;
        conv = 1;
        break;
      end
      den = rr_q < fl ? fl : rr_q;
      beta = q16_ratio(rr_new, den);
      p_q = scaled_add(r_q, beta, p_q, n);
      rr_q = rr_new;
    end
    for (int i = 0; i < n; i++) begin
      b.index = 4'(i);
      b.solution = x_q[i];
      b.last = (i == n - 1);
      b.converged = conv;
      b.iterations = 5'(it);
      solution_fifo.push_back(b);
    end
  endtask

  // one beat on s_axis; valid stays high afterward unless the next call idles
  task automatic send_beat(input mode_e mode, input logic [3:0] row, input logic [3:0] col,
                           input logic [31:0] value);
    if (!calm && $urandom_range(99) < 23) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= {value, col, row};
    do @(posedge clk_i); while (!s_axis_tready);
    case (mode)
      MODE_LOAD_A: begin
        mat_q[{row, col}] = value;
        mat_set[{row, col}] = 1'b1;
      end
      MODE_LOAD_B: begin
        rhs_q[row] = value;
        rhs_set[row] = 1'b1;
      end
      MODE_SOLVE: predict_solve();
      default: ;
    endcase
  endtask

  task automatic hold_input();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // wait for every solution beat, then let the block settle
  task automatic drain();
    hold_input();
    while (solution_fifo.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegSize:  cfg_size = value[4:0];
      RegFloor: cfg_floor = value[15:0];
      RegTol:   cfg_tol = value;
      default: ;
    endcase
  endtask

  function automatic int unknowns();
    return cfg_size == 0 ? 1 : (cfg_size > Dim ? Dim : int'(cfg_size));
  endfunction

  // load any entry the next solve would read that was never written
  task automatic fill_gaps();
    int n;
    n = unknowns();
    for (int i = 0; i < n; i++) begin
      if (!rhs_set[i]) send_beat(MODE_LOAD_B, 4'(i), 4'($urandom), $urandom_range(131072));
      for (int j = 0; j < n; j++)
        if (!mat_set[i*Dim + j])
          send_beat(MODE_LOAD_A, 4'(i), 4'(j), i == j ? 32'h0004_0000 : 32'h0000_2000);
    end
  endtask

  // symmetric, diagonally dominant system with random content, then solve
  task automatic solve_well_formed();
    int n;
    logic [31:0] v;
    n = unknowns();
    for (int i = 0; i < n; i++) begin
      for (int j = i; j < n; j++) begin
        v = (i == j) ? 32'($urandom_range(1 << 20, 1 << 17)) : 32'($signed($urandom_range(16384)) - 8192);
        send_beat(MODE_LOAD_A, 4'(i), 4'(j), v);
        if (i != j) send_beat(MODE_LOAD_A, 4'(j), 4'(i), v);
      end
      send_beat(MODE_LOAD_B, 4'(i), 4'($urandom), 32'($signed($urandom_range(1 << 20)) - (1 << 19)));
    end
    send_beat(MODE_SOLVE, 4'($urandom), 4'($urandom), $urandom);
  endtask

  task automatic test_directed();
    write_reg(RegSize, 32'd2);
    write_reg(RegFloor, 32'd1);
    write_reg(RegTol, 32'd1);
    // extremes of the value field and a mode three beat that must be ignored
    send_beat(MODE_LOAD_A, 4'd0, 4'd0, 32'h7FFF_FFFF);
    send_beat(MODE_LOAD_A, 4'd0, 4'd1, 32'h8000_0000);
    send_beat(MODE_LOAD_A, 4'd1, 4'd0, 32'h8000_0000);
    send_beat(MODE_LOAD_A, 4'd1, 4'd1, 32'h7FFF_FFFF);
    send_beat(MODE_LOAD_B, 4'd0, 4'd15, 32'h7FFF_FFFF);
    send_beat(MODE_LOAD_B, 4'd1, 4'd0, 32'h8000_0000);
    send_beat(MODE_NONE, 4'd15, 4'd15, 32'hFFFF_FFFF);
    send_beat(MODE_SOLVE, 4'd0, 4'd0, 32'd0);
    // top corner indexes, identity system that converges at once
    send_beat(MODE_LOAD_A, 4'd15, 4'd15, 32'h0001_0000);
    send_beat(MODE_LOAD_B, 4'd15, 4'd15, 32'd0);
    send_beat(MODE_LOAD_A, 4'd0, 4'd0, 32'h0001_0000);
    send_beat(MODE_LOAD_A, 4'd0, 4'd1, 32'd0);
    send_beat(MODE_LOAD_A, 4'd1, 4'd0, 32'd0);
    send_beat(MODE_LOAD_A, 4'd1, 4'd1, 32'h0001_0000);
    send_beat(MODE_LOAD_B, 4'd0, 4'd0, 32'h0003_0000);
    send_beat(MODE_LOAD_B, 4'd1, 4'd0, 32'hFFFE_0000);
    send_beat(MODE_SOLVE, 4'd15, 4'd15, 32'hFFFF_FFFF);
    drain();
  endtask

  task automatic test_config_extremes();
    // size zero acts as one; zero floor acts as one; zero tolerance never stops early
    write_reg(RegSize, 32'd0);
    write_reg(RegFloor, 32'd0);
    write_reg(RegTol, 32'd0);
    send_beat(MODE_SOLVE, 4'd0, 4'd0, 32'd0);
    drain();
    write_reg(RegFloor, 32'hFFFF);
    write_reg(RegTol, 32'hFFFF_FFFF);
    write_reg(RegSize, 32'd3);
    solve_well_formed();
    drain();
    // largest size, then an oversize value that clamps to it
    write_reg(RegFloor, 32'd1);
    write_reg(RegTol, 32'd1);
    write_reg(RegSize, 32'd16);
    fill_gaps();
    send_beat(MODE_SOLVE, 4'd0, 4'd0, 32'd0);
    drain();
    write_reg(RegSize, 32'd31);
    send_beat(MODE_SOLVE, 4'd0, 4'd0, 32'd0);
    drain();
  endtask

  task automatic test_random();
    int sent;
    int pick;
    sent = 0;
    while (sent < 110) begin
      write_reg(RegSize, 32'($urandom_range(5, 1)));
      write_reg(RegFloor, 32'($urandom_range(65535)));
      write_reg(RegTol, $urandom_range(3) == 0 ? $urandom : 32'($urandom_range(1 << 24)));
      calm = ($urandom_range(4) == 0);
      pick = $urandom_range(9);
      if (pick < 6) begin
        solve_well_formed();
        sent += unknowns() * (unknowns() + 2) + 1;
      end else begin
        // noise: full-range loads, ignored beats, then a solve on whatever is there
        repeat ($urandom_range(6, 2)) begin
          send_beat(mode_e'($urandom_range(3) == 0 ? MODE_NONE :
                            ($urandom_range(1) ? MODE_LOAD_A : MODE_LOAD_B)),
                    4'($urandom), 4'($urandom), $urandom);
          sent++;
        end
        fill_gaps();
        send_beat(MODE_SOLVE, 4'($urandom), 4'($urandom), $urandom);
        sent++;
      end
      drain();
    end
    calm = 1'b0;
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 23);
  end

  always @(posedge clk_i) begin
    sol_beat_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (solution_fifo.size() == 0) begin
        report("solution beat with nothing expected");
      end else begin
        e = solution_fifo.pop_front();
        if (m_axis_tdata[3:0] !== e.index)
          report($sformatf("index %0d, want %0d", m_axis_tdata[3:0], e.index));
        if (m_axis_tdata[35:4] !== e.solution)
          report($sformatf("solution %h, want %h (index %0d)", m_axis_tdata[35:4],
                           e.solution, e.index));
        if (m_axis_tlast !== e.last)
          report($sformatf("last %b, want %b", m_axis_tlast, e.last));
        if (m_axis_tuser !== e.converged)
          report($sformatf("converged %b, want %b", m_axis_tuser, e.converged));
        if (m_axis_tdata[40:36] !== e.iterations)
          report($sformatf("iterations %0d, want %0d", m_axis_tdata[40:36], e.iterations));
      end
    end
  end

  // watchdog on cycles without any accepted beat or APB select
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("tb_conjugate_gradient_solver: errors");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_extremes();
    test_random();
    drain();
    if (err_cnt == 0 && solution_fifo.size() == 0)
      $display("tb_conjugate_gradient_solver: clean");
    else
      $display("tb_conjugate_gradient_solver: errors");
    $finish;
  end

endmodule

// ----- conjugate_gradient_solver.f -----
hw/rtl/cgs_pkg.sv
hw/rtl/cgs_ram.sv
hw/rtl/cgs_div.sv
hw/rtl/cgs_datapath.sv
hw/rtl/cgs_ctrl.sv
hw/rtl/conjugate_gradient_solver.sv
test/tb_conjugate_gradient_solver.sv
